// File: rtl/prq_pkg.sv
// Package for the priority ready queue scheduler: default sizes, field widths,
// request, task-state and response codes. Used by priority_ready_queue_scheduler.
package prq_pkg;

   localparam int PRQ_TASKS  = 64;
   localparam int PRQ_LEVELS = 16;

   localparam int REQ_TDATA_W = 16;   // 13 payload bits padded to whole bytes
   localparam int RSP_TDATA_W = 24;   // 17 payload bits padded to whole bytes

   typedef enum logic [0:0] {
      REQ_INSERT = 1'b0,
      REQ_POP    = 1'b1
   } req_code_type;

   typedef enum logic [2:0] {
      TS_ACTIVE       = 3'd0,
      TS_READY        = 3'd1,
      TS_SEND_BLOCKED = 3'd2,
      TS_RECV_BLOCKED = 3'd3,
      TS_REPLY_BLOCKED = 3'd4,
      TS_AWAIT_EVENT  = 3'd5,
      TS_DEFUNCT      = 3'd6
   } task_state_type;

   typedef enum logic [1:0] {
      RSP_INSERTED   = 2'd0,
      RSP_IGNORED    = 2'd1,
      RSP_POPPED     = 2'd2,
      RSP_NONE_READY = 2'd3
   } rsp_code_type;

endpackage

// File: rtl/priority_ready_queue_scheduler.sv
// Multilevel priority ready queue: top level with sequencer, link memories and
// the shared level-scan incrementer. Depends on prq_pkg.
//
// Usage:
//   req channel (req_tvalid/req_tready/req_tuser/req_tdata) carries one request
//   per transfer: insert a runnable task at the tail of its level's FIFO, or pop
//   the head of the most urgent non-empty level. rsp channel returns exactly
//   one result per request, in order.
//   An insert reads its level's head and tail, then updates the stores and
//   builds its result; a pop that leaves its level non-empty then writes its
//   successor as the new head; a pop that drains its level scans the less
//   urgent levels, at most LEVELS steps. The scan runs through one shared
//   incrementer and compare, one level per cycle; head, tail and link stores
//   are memories with registered reads, which sets the read-then-use cycles.
//   The block takes one request at a time and is ready only in its idle
//   state, entered as the result is loaded. The result register is separate,
//   so a new request is taken while the previous result still waits.
//   Reset: all levels empty, top level reads LEVELS, no result pending.
//   Stall: when rsp_tready is low the finished result is held and the
//   sequencer waits before loading the next one; nothing is dropped.
module priority_ready_queue_scheduler
   import prq_pkg::*;
#(
   parameter int TASKS  = PRQ_TASKS,
   parameter int LEVELS = PRQ_LEVELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,   // [0] req_type
   // [5:0] task_index, [9:6] prio_level, [12:10] task_status
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] status, [7:2] popped_index, [11:8] popped_level, [16:12] top_level
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int TASK_W = $clog2(TASKS);
   localparam int LIDX_W = $clog2(LEVELS);
   localparam int LVL_W  = $clog2(LEVELS + 1);
   localparam logic [LVL_W-1:0] NO_LEVEL = LVL_W'(LEVELS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_LINK,
      S_SCAN,
      S_DONE
   } state_type;

   // request fields
   logic       req_code;
   logic [5:0] task_index;
   logic [3:0] prio_level;
   logic [2:0] task_status;

   assign req_code    = req_tuser;
   assign task_index  = req_tdata[5:0];
   assign prio_level  = req_tdata[9:6];
   assign task_status = req_tdata[12:10];

   // stores
   logic [TASK_W-1:0] level_head [LEVELS];
   logic [TASK_W-1:0] level_tail [LEVELS];
   logic [TASK_W-1:0] next_link  [TASKS];
   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [LVL_W-1:0]  best_ff, best_in;

   // registered read data
   logic [TASK_W-1:0] head_rd_ff, tail_rd_ff, link_rd_ff;

   // sequencer state and latched request
   state_type         state_ff, state_in;
   logic              pop_ff, pop_in;
   logic              ok_ff, ok_in;
   logic [TASK_W-1:0] slot_ff, slot_in;
   logic [LIDX_W-1:0] lvl_ff, lvl_in;
   logic [LVL_W-1:0]  scan_ff, scan_in;

   // finished result and output register
   logic [1:0]        res_code_ff, res_code_in;
   logic [TASK_W-1:0] res_idx_ff, res_idx_in;
   logic [LIDX_W-1:0] res_lvl_ff, res_lvl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic [LIDX_W-1:0] lvl_rd_addr;
   logic              head_we, tail_we, link_we;
   logic [TASK_W-1:0] head_wd;
   logic [TASK_W-1:0] link_wa, link_ra;

   logic              req_fire;
   logic [LIDX_W-1:0] sat_lvl;
   logic              runnable;
   logic              slot_fits;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // saturate the level, qualify the slot and the task state
   assign sat_lvl   = (32'(prio_level) >= LEVELS) ? LIDX_W'(LEVELS - 1)
                                                  : LIDX_W'(prio_level);
   assign runnable  = (task_status == TS_ACTIVE) || (task_status == TS_READY);
   assign slot_fits = 32'(task_index) < TASKS;

   // pop reads the top level; insert reads its own level
   assign lvl_rd_addr = (state_ff == S_IDLE)
                        ? ((req_code == REQ_POP) ? LIDX_W'(best_ff) : sat_lvl)
                        : lvl_ff;

   assign head_we = ((state_ff == S_EXEC) && !pop_ff && ok_ff && !nonempty_ff[lvl_ff])
                    || (state_ff == S_LINK);
   assign head_wd = (state_ff == S_LINK) ? link_rd_ff : slot_ff;
   assign tail_we = (state_ff == S_EXEC) && !pop_ff && ok_ff;
   assign link_we = (state_ff == S_EXEC) && !pop_ff && ok_ff && nonempty_ff[lvl_ff];
   assign link_wa = tail_rd_ff;
   assign link_ra = head_rd_ff;

   always_ff @(posedge clock) begin
      if (head_we) begin
         level_head[lvl_ff] <= head_wd;
      end
      head_rd_ff <= level_head[lvl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         level_tail[lvl_ff] <= slot_ff;
      end
      tail_rd_ff <= level_tail[lvl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         next_link[link_wa] <= slot_ff;
      end
      link_rd_ff <= next_link[link_ra];
   end

   always_comb begin
      state_in     = state_ff;
      pop_in       = pop_ff;
      ok_in        = ok_ff;
      slot_in      = slot_ff;
      lvl_in       = lvl_ff;
      scan_in      = scan_ff;
      nonempty_in  = nonempty_ff;
      best_in      = best_ff;
      res_code_in  = res_code_ff;
      res_idx_in   = res_idx_ff;
      res_lvl_in   = res_lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pop_in  = (req_code == REQ_POP);
               ok_in   = (req_code == REQ_POP) ? (best_ff < NO_LEVEL)
                                               : (runnable && slot_fits);
               slot_in = TASK_W'(task_index);
               lvl_in  = lvl_rd_addr;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // head and tail of the addressed level are being read
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_idx_in = '0;
            res_lvl_in = '0;
            state_in   = S_DONE;
            if (!pop_ff) begin
               if (ok_ff) begin
                  nonempty_in[lvl_ff] = 1'b1;
                  if (LVL_W'(lvl_ff) < best_ff) begin
                     best_in = LVL_W'(lvl_ff);
                  end
                  res_code_in = RSP_INSERTED;
               end else begin
                  res_code_in = RSP_IGNORED;
               end
            end else if (!ok_ff || !nonempty_ff[lvl_ff]) begin
               res_code_in = RSP_NONE_READY;
            end else begin
               res_code_in = RSP_POPPED;
               res_idx_in  = head_rd_ff;
               res_lvl_in  = lvl_ff;
               if (head_rd_ff == tail_rd_ff) begin
                  // level drains: scan toward less urgent levels
                  nonempty_in[lvl_ff] = 1'b0;
                  scan_in  = LVL_W'(lvl_ff) + LVL_W'(1);
                  state_in = S_SCAN;
               end else begin
                  state_in = S_LINK;
               end
            end
         end
         S_LINK: begin
            // successor read done; head write happens this cycle
            state_in = S_DONE;
         end
         S_SCAN: begin
            if ((scan_ff < NO_LEVEL) && !nonempty_ff[scan_ff[LIDX_W-1:0]]) begin
               scan_in = scan_ff + LVL_W'(1);
            end else begin
               best_in  = scan_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[1:0]   = res_code_ff;
               rsp_data_in[7:2]   = 6'(res_idx_ff);
               rsp_data_in[11:8]  = 4'(res_lvl_ff);
               rsp_data_in[16:12] = 5'(best_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         best_ff      <= NO_LEVEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pop_ff      <= pop_in;
      ok_ff       <= ok_in;
      slot_ff     <= slot_in;
      lvl_ff      <= lvl_in;
      scan_ff     <= scan_in;
      res_code_ff <= res_code_in;
      res_idx_ff  <= res_idx_in;
      res_lvl_ff  <= res_lvl_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: verif/priority_ready_queue_scheduler_tb.sv
// Self-checking testbench for priority_ready_queue_scheduler: directed and random
// insert/pop traffic with random idling on both stream channels. Depends on prq_pkg.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_tb;
   import prq_pkg::*;

   // Status code seven has no name in the package; the block ignores it like any non-runnable status.
   localparam logic [2:0] TS_UNUSED_CODE = 3'd7;
   localparam int         RANDOM_ITEMS   = 1250;
   localparam int         PHASES         = 5;
   localparam int         DRAIN_LIMIT    = 3 * PRQ_TASKS;

   typedef struct packed {
      rsp_code_type status;
      logic [5:0]   popped_index;
      logic [3:0]   popped_level;
      logic [4:0]   top_level;
   } sched_result_type;

   // Tracks the per-level FIFOs alongside the block and predicts every result.
   class ready_queue_scoreboard;
      logic [5:0]    head_slot [PRQ_LEVELS];
      logic [5:0]    tail_slot [PRQ_LEVELS];
      bit            level_busy [PRQ_LEVELS];
      logic [5:0]    link_slot [PRQ_TASKS];
      bit            link_written [PRQ_TASKS];
      logic [4:0]    top_lvl;
      bit            slot_queued [PRQ_TASKS];
      int            queued_count;
      int            links_written;
      int            peak_queued;
      sched_result_type pending_results [$];
      int            error_count;
      int            checked_count;
      int            pop_count;
      int            none_ready_count;
      int            ignored_count;

      function new();
         foreach (level_busy[i]) level_busy[i] = 1'b0;
         foreach (link_written[i]) link_written[i] = 1'b0;
         foreach (slot_queued[i]) slot_queued[i] = 1'b0;
         top_lvl          = 5'(PRQ_LEVELS);
         queued_count     = 0;
         links_written    = 0;
         peak_queued      = 0;
         error_count      = 0;
         checked_count    = 0;
         pop_count        = 0;
         none_ready_count = 0;
         ignored_count    = 0;
      endfunction

      // Apply one accepted request to the shadow queues and queue its result.
      function void note_request(req_code_type kind, logic [5:0] slot,
                                 logic [3:0] lvl, logic [2:0] st);
         sched_result_type res;
         int            p;
         int            q;
         res = '{status: RSP_INSERTED, popped_index: '0, popped_level: '0, top_level: '0};
         if (kind == REQ_INSERT) begin
            if (st != TS_ACTIVE && st != TS_READY) begin
               res.status = RSP_IGNORED;
               ignored_count++;
            end else begin
               if (level_busy[lvl]) begin
                  link_slot[tail_slot[lvl]] = slot;
                  if (!link_written[tail_slot[lvl]]) links_written++;
                  link_written[tail_slot[lvl]] = 1'b1;
                  tail_slot[lvl] = slot;
               end else begin
                  head_slot[lvl]  = slot;
                  tail_slot[lvl]  = slot;
                  level_busy[lvl] = 1'b1;
               end
               if (5'(lvl) < top_lvl) top_lvl = 5'(lvl);
               if (!slot_queued[slot]) queued_count++;
               slot_queued[slot] = 1'b1;
               if (queued_count > peak_queued) peak_queued = queued_count;
            end
         end else begin
            p = top_lvl;
            if (p >= PRQ_LEVELS || !level_busy[p]) begin
               res.status = RSP_NONE_READY;
               none_ready_count++;
            end else begin
               res.status       = RSP_POPPED;
               res.popped_index = head_slot[p];
               res.popped_level = 4'(p);
               pop_count++;
               if (head_slot[p] == tail_slot[p]) begin
                  // Level drained: advance to the next non-empty level.
                  level_busy[p] = 1'b0;
                  q = p + 1;
                  while (q < PRQ_LEVELS && !level_busy[q]) q++;
                  top_lvl = 5'(q);
               end else begin
                  head_slot[p] = link_slot[head_slot[p]];
               end
               if (slot_queued[res.popped_index]) queued_count--;
               slot_queued[res.popped_index] = 1'b0;
               // Once every level is empty, the occupancy map is exact again.
               if (top_lvl == 5'(PRQ_LEVELS)) begin
                  foreach (slot_queued[i]) slot_queued[i] = 1'b0;
                  queued_count = 0;
               end
            end
         end
         res.top_level = top_lvl;
         pending_results.push_back(res);
      endfunction

      // Compare one accepted response with the oldest outstanding prediction.
      function void check_result(logic [RSP_TDATA_W-1:0] data);
         sched_result_type want;
         sched_result_type got;
         got.status       = rsp_code_type'(data[1:0]);
         got.popped_index = data[7:2];
         got.popped_level = data[11:8];
         got.top_level    = data[16:12];
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d, no request outstanding", got.status);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.popped_index !== want.popped_index) begin
            $error("popped_index mismatch: expected %0d, got %0d",
                   want.popped_index, got.popped_index);
            error_count++;
         end
         if (got.popped_level !== want.popped_level) begin
            $error("popped_level mismatch: expected %0d, got %0d",
                   want.popped_level, got.popped_level);
            error_count++;
         end
         if (got.top_level !== want.top_level) begin
            $error("top_level mismatch: expected %0d, got %0d", want.top_level, got.top_level);
            error_count++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser  = 1'b0;   // [0] req_type
   // [5:0] task_index, [9:6] prio_level, [12:10] task_status
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [1:0] status, [7:2] popped_index, [11:8] popped_level, [16:12] top_level
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   ready_queue_scoreboard sb;
   bit                    req_idle_on = 1'b1;
   bit                    rsp_idle_on = 1'b1;
   int                    sent_count  = 0;

   priority_ready_queue_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Offer one request, after a random gap when request idling is on, and hold it until the transfer.
   // Keep tvalid high across back-to-back requests; lower it only for a gap.
   task automatic send_request(input req_code_type kind, input logic [5:0] slot,
                               input logic [3:0] lvl, input logic [2:0] st);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, st, lvl, slot};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, slot, lvl, st);
      sent_count++;
   endtask

   task automatic send_pop();
      send_request(REQ_POP, 6'($urandom), 4'($urandom), 3'($urandom));
   endtask

   // Pop until every level is empty, with a cap in case corrupted links cycle.
   task automatic drain_all_levels();
      int n;
      n = 0;
      while (sb.top_lvl != 5'(PRQ_LEVELS) && n < DRAIN_LIMIT) begin
         send_pop();
         n++;
      end
   endtask

   // Directed corners: empty pops, both extreme slots and levels, every
   // non-runnable status, FIFO order within a level, level scan on drain,
   // and a re-insert of a task already queued at its own level.
   task automatic run_directed();
      send_pop();
      send_request(REQ_INSERT, 6'd63, 4'd15, TS_READY);
      send_request(REQ_INSERT, 6'd0, 4'd0, TS_ACTIVE);
      for (int s = TS_SEND_BLOCKED; s <= TS_UNUSED_CODE; s++)
         send_request(REQ_INSERT, 6'd42, 4'd7, 3'(s));
      send_pop();
      send_pop();
      send_pop();
      send_request(REQ_INSERT, 6'd5, 4'd3, TS_READY);
      send_request(REQ_INSERT, 6'd6, 4'd3, TS_ACTIVE);
      send_request(REQ_INSERT, 6'd7, 4'd3, TS_READY);
      send_request(REQ_INSERT, 6'd21, 4'd9, TS_ACTIVE);
      send_request(REQ_INSERT, 6'd22, 4'd1, TS_READY);
      repeat (5) send_pop();
      send_request(REQ_INSERT, 6'd9, 4'd2, TS_READY);
      send_request(REQ_INSERT, 6'd9, 4'd2, TS_READY);
      send_pop();
      send_pop();
   endtask

   // Random traffic: alternate fill and drain stretches so queues get deep
   // and empty again; some stretches crowd a few levels to build long FIFOs.
   // Re-inserting a queued task is allowed only after every link entry has
   // been written, so a corrupted chain never reads an unwritten link.
   task automatic run_random(input int count);
      int         pop_pct;
      int         base_lvl;
      bit         narrow;
      logic [5:0] slot;
      logic [3:0] lvl;
      logic [2:0] st;
      base_lvl = 0;
      for (int i = 0; i < count; i++) begin
         pop_pct = ((i / 60) % 2 == 0) ? 25 : 70;
         narrow  = ((i / 40) % 3 == 1);
         if (i % 40 == 0) base_lvl = $urandom_range(0, PRQ_LEVELS - 4);
         if (sb.queued_count == 0 && $urandom_range(0, 99) < 80) pop_pct = 0;
         if (sb.queued_count >= PRQ_TASKS) pop_pct = 100;
         if ($urandom_range(0, 99) < pop_pct) begin
            send_pop();
         end else begin
            if (sb.links_written == PRQ_TASKS && $urandom_range(0, 99) < 5) begin
               slot = 6'($urandom);
            end else begin
               do slot = 6'($urandom); while (sb.slot_queued[slot]);
            end
            lvl = narrow ? 4'(base_lvl + $urandom_range(0, 3)) : 4'($urandom);
            st  = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(TS_ACTIVE, TS_READY))
                                               : 3'($urandom);
            send_request(REQ_INSERT, slot, lvl, st);
         end
      end
   endtask

   // Result sink: when response idling is on, stall for a random gap before each result, then take it.
   initial begin : rsp_sink
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   // Stimulus and end of run.
   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Phases cycle through the idling combinations, including none at all.
      for (int ph = 0; ph < PHASES; ph++) begin
         req_idle_on = (ph != 1) && (ph != 3);
         rsp_idle_on = (ph != 1) && (ph != 2);
         run_random(RANDOM_ITEMS / PHASES - 20);
         drain_all_levels();
      end
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests, checked %0d results: %0d pops, %0d none-ready, %0d ignored.",
               sent_count, sb.checked_count, sb.pop_count, sb.none_ready_count,
               sb.ignored_count);
      $display("Deepest occupancy %0d tasks; %0d of %0d link entries exercised.",
               sb.peak_queued, sb.links_written, PRQ_TASKS);
      if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
         $display("priority_ready_queue_scheduler test passed");
      end else begin
         $display("priority_ready_queue_scheduler test failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("priority_ready_queue_scheduler test failed");
      $finish;
   end

endmodule

// File: priority_ready_queue_scheduler.f
rtl/prq_pkg.sv
rtl/priority_ready_queue_scheduler.sv
verif/priority_ready_queue_scheduler_tb.sv
